/* rtl/sse_pkg.sv */
package sse_pkg;

   typedef enum logic [2:0] {
      CMD_CAN_FRAME  = 3'd0,
      CMD_TICK       = 3'd1,
      CMD_EXT_STOP   = 3'd2,
      CMD_CLEAR      = 3'd3,
      CMD_SET_ENABLE = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      CAUSE_NONE      = 3'd0,
      CAUSE_EXTERNAL  = 3'd1,
      CAUSE_BTN_EVENT = 3'd2,
      CAUSE_BTN_STAT  = 3'd3,
      CAUSE_HB_LOST   = 3'd4
   } cause_type;

   typedef enum logic [2:0] {
      REG_BUTTON_BASE = 3'd0,
      REG_HB_TIMEOUT  = 3'd1,
      REG_FEATURES    = 3'd2,
      REG_DRIVE_A     = 3'd3,
      REG_DRIVE_B     = 3'd4,
      REG_MOTOR_A     = 3'd5,
      REG_MOTOR_B     = 3'd6
   } reg_index_type;

   typedef enum logic [2:0] {
      SLOT_NODE_A      = 3'd0,
      SLOT_NODE_B      = 3'd1,
      SLOT_MOTOR_A_ON  = 3'd2,
      SLOT_MOTOR_A_OFF = 3'd3,
      SLOT_MOTOR_B_ON  = 3'd4,
      SLOT_MOTOR_B_OFF = 3'd5
   } slot_type;

   // feature_enables bit positions
   localparam int FE_DIRECT  = 0;
   localparam int FE_NODE_A  = 1;
   localparam int FE_NODE_B  = 2;
   localparam int FE_MOTOR_A = 3;
   localparam int FE_MOTOR_B = 4;
   localparam int FE_BUTTON  = 5;

   localparam logic [4:0]  ESTOP_ID_LOW   = 5'h02;
   localparam logic [63:0] MOTOR_STOP     = 64'h81;
   localparam logic [63:0] MOTOR_OFF      = 64'h80;
   localparam logic [7:0]  BTN_PRESSED    = 8'h01;
   localparam logic [7:0]  BTN_STAT_MASK  = 8'h11;
   localparam logic [3:0]  FULL_LENGTH    = 4'd8;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef struct packed {
      logic [10:0] button_base_id;
      logic [15:0] hb_timeout;
      logic [5:0]  features;
      logic [5:0]  drive_node_a;
      logic [5:0]  drive_node_b;
      logic [10:0] motor_id_a;
      logic [10:0] motor_id_b;
   } cfg_type;

   // one queued job: burst count, state for every result, status-word clear flag
   typedef struct packed {
      logic [1:0] bursts;
      logic       latched;
      logic       active;
      cause_type  cause;
      logic       clear_done;
   } job_type;

endpackage

/* rtl/sse_regs.sv */
module sse_regs (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output sse_pkg::cfg_type cfg
);
   import sse_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[4:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_BUTTON_BASE: cfg_in.button_base_id = pwdata[10:0];
            REG_HB_TIMEOUT:  cfg_in.hb_timeout     = pwdata[15:0];
            REG_FEATURES:    cfg_in.features       = pwdata[5:0];
            REG_DRIVE_A:     cfg_in.drive_node_a   = pwdata[5:0];
            REG_DRIVE_B:     cfg_in.drive_node_b   = pwdata[5:0];
            REG_MOTOR_A:     cfg_in.motor_id_a     = pwdata[10:0];
            REG_MOTOR_B:     cfg_in.motor_id_b     = pwdata[10:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_BUTTON_BASE: prdata = {21'd0, cfg_ff.button_base_id};
         REG_HB_TIMEOUT:  prdata = {16'd0, cfg_ff.hb_timeout};
         REG_FEATURES:    prdata = {26'd0, cfg_ff.features};
         REG_DRIVE_A:     prdata = {26'd0, cfg_ff.drive_node_a};
         REG_DRIVE_B:     prdata = {26'd0, cfg_ff.drive_node_b};
         REG_MOTOR_A:     prdata = {21'd0, cfg_ff.motor_id_a};
         REG_MOTOR_B:     prdata = {21'd0, cfg_ff.motor_id_b};
         default:         prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.button_base_id <= 11'd512;
         cfg_ff.hb_timeout     <= 16'd240;
         cfg_ff.features       <= 6'd63;
         cfg_ff.drive_node_a   <= 6'd0;
         cfg_ff.drive_node_b   <= 6'd2;
         cfg_ff.motor_id_a     <= 11'd321;
         cfg_ff.motor_id_b     <= 11'd322;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/sse_front.sv */
module sse_front (
   input  logic             clock,
   input  logic             reset,
   input  sse_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [2:0]       in_command,
   input  logic [10:0]      in_rx_id,
   input  logic [3:0]       in_rx_length,
   input  logic [63:0]      in_rx_bytes,
   input  logic             in_flag,
   input  logic             queue_full,
   output logic             push,
   output sse_pkg::job_type push_job
);
   import sse_pkg::*;

   logic        latched_ff, latched_in;
   logic        enabled_ff, enabled_in;
   cause_type   cause_ff, cause_in;
   logic        hb_seen_ff, hb_seen_in;
   logic [15:0] hb_value_ff, hb_value_in;
   logic [15:0] ticks_ff, ticks_in;

   logic        accept;
   logic        emit;
   logic [1:0]  bursts;
   logic        clear_done;
   logic        monitor;
   logic [10:0] status_id;
   logic [15:0] hb;
   logic [15:0] ticks_inc;
   logic        timeout_hit;
   logic        is_event, is_stat_latch, is_stat_hb;

   assign in_ready  = !queue_full;
   assign accept    = in_valid && in_ready;
   assign monitor   = cfg.features[FE_BUTTON];
   assign status_id = cfg.button_base_id + 11'd1;
   assign hb        = {in_rx_bytes[55:48], in_rx_bytes[63:56]};
   assign ticks_inc = (ticks_ff != 16'hFFFF) ? ticks_ff + 16'd1 : ticks_ff;
   assign timeout_hit = enabled_ff && monitor && !latched_ff && hb_seen_ff &&
                        (ticks_inc > cfg.hb_timeout);

   assign is_event      = (in_rx_id == cfg.button_base_id) && (in_rx_length != 4'd0) &&
                          (in_rx_bytes[7:0] == BTN_PRESSED);
   assign is_stat_latch = (in_rx_id == status_id) && (in_rx_length >= 4'd2) &&
                          ((in_rx_bytes[15:8] & BTN_STAT_MASK) != 8'd0);
   assign is_stat_hb    = (in_rx_id == status_id) && (in_rx_length >= FULL_LENGTH);

   always_comb begin
      latched_in  = latched_ff;
      enabled_in  = enabled_ff;
      cause_in    = cause_ff;
      hb_seen_in  = hb_seen_ff;
      hb_value_in = hb_value_ff;
      ticks_in    = ticks_ff;
      emit        = 1'b0;
      bursts      = 2'd0;
      clear_done  = 1'b0;
      case (cmd_type'(in_command))
         CMD_CAN_FRAME: begin
            if (enabled_ff && monitor) begin
               if (is_event) begin
                  latched_in = 1'b1;
                  cause_in   = CAUSE_BTN_EVENT;
                  emit       = 1'b1;
                  bursts     = 2'd1;
               end else if (is_stat_latch) begin
                  if (is_stat_hb) begin
                     hb_value_in = hb;
                     hb_seen_in  = 1'b1;
                     ticks_in    = 16'd0;
                  end
                  latched_in = 1'b1;
                  cause_in   = CAUSE_BTN_STAT;
                  emit       = 1'b1;
                  bursts     = 2'd1;
               end else if (is_stat_hb && (!hb_seen_ff || hb != hb_value_ff)) begin
                  hb_value_in = hb;
                  hb_seen_in  = 1'b1;
                  ticks_in    = 16'd0;
               end
            end
         end
         CMD_TICK: begin
            ticks_in = ticks_inc;
            emit     = 1'b1;
            if (timeout_hit) begin
               latched_in = 1'b1;
               cause_in   = CAUSE_HB_LOST;
            end
            // a watchdog latch sends its own burst, then the latched burst again
            bursts = {1'b0, timeout_hit} +
                     {1'b0, enabled_ff && (latched_ff || timeout_hit)};
         end
         CMD_EXT_STOP: begin
            if (enabled_ff) begin
               latched_in = 1'b1;
               cause_in   = CAUSE_EXTERNAL;
               emit       = 1'b1;
               bursts     = 2'd1;
            end
         end
         CMD_CLEAR: begin
            emit       = 1'b1;
            clear_done = in_flag;
            if (in_flag) begin
               latched_in = 1'b0;
               cause_in   = CAUSE_NONE;
            end
         end
         CMD_SET_ENABLE: begin
            emit       = 1'b1;
            enabled_in = in_flag;
            if (!in_flag) begin
               latched_in = 1'b0;
               cause_in   = CAUSE_NONE;
            end
         end
         default: emit = 1'b0;
      endcase
   end

   assign push                = accept && emit;
   assign push_job.bursts     = bursts;
   assign push_job.latched    = latched_in;
   assign push_job.active     = enabled_in;
   assign push_job.cause      = cause_in;
   assign push_job.clear_done = clear_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         latched_ff  <= 1'b0;
         enabled_ff  <= 1'b1;
         cause_ff    <= CAUSE_NONE;
         hb_seen_ff  <= 1'b0;
         hb_value_ff <= 16'd0;
         ticks_ff    <= 16'd0;
      end else if (accept) begin
         latched_ff  <= latched_in;
         enabled_ff  <= enabled_in;
         cause_ff    <= cause_in;
         hb_seen_ff  <= hb_seen_in;
         hb_value_ff <= hb_value_in;
         ticks_ff    <= ticks_in;
      end
   end

endmodule

/* rtl/sse_queue.sv */
module sse_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sse_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             job_valid,
   output sse_pkg::job_type job
);
   import sse_pkg::*;

   localparam logic [QUEUE_AW:0] DEPTH = (QUEUE_AW + 1)'(QUEUE_DEPTH);

   job_type               slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_pop;

   assign full      = (count_ff == DEPTH);
   assign job_valid = (count_ff != '0);
   assign job       = slots_ff[rd_ptr_ff];
   assign do_pop    = pop && job_valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/sse_back.sv */
module sse_back #(
   parameter int DRIVE_NODES = 2,
   parameter int MOTOR_IDS   = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  sse_pkg::cfg_type cfg,
   input  logic             job_valid,
   input  sse_pkg::job_type job,
   output logic             pop,
   output logic             out_valid,
   input  logic             out_ready,
   output logic             out_kind,
   output logic [10:0]      out_tx_id,
   output logic [3:0]       out_tx_length,
   output logic [63:0]      out_tx_bytes,
   output logic             out_latched,
   output logic             out_active,
   output logic [2:0]       out_stop_cause,
   output logic             out_clear_done,
   output logic             out_last
);
   import sse_pkg::*;

   localparam logic HAS_NODE_B  = (DRIVE_NODES >= 2);
   localparam logic HAS_MOTOR_B = (MOTOR_IDS >= 2);

   slot_type    slot_ff, slot_in;
   logic [1:0]  pass_ff, pass_in;
   logic        valid_ff, valid_in;
   logic        kind_ff, kind_in;
   logic [10:0] id_ff, id_in;
   logic [3:0]  len_ff, len_in;
   logic [63:0] bytes_ff, bytes_in;
   logic        latched_ff, latched_in;
   logic        active_ff, active_in;
   logic [2:0]  cause_ff, cause_in;
   logic        clear_ff, clear_in;
   logic        last_ff, last_in;

   logic        step;
   logic        in_burst;
   logic        slot_en;
   logic        load;
   logic [10:0] slot_id;
   logic [3:0]  slot_len;
   logic [63:0] slot_bytes;

   assign step     = job_valid && (!valid_ff || out_ready);
   assign in_burst = (pass_ff < job.bursts);

   always_comb begin
      slot_en    = 1'b0;
      slot_id    = '0;
      slot_len   = 4'd0;
      slot_bytes = '0;
      case (slot_ff)
         SLOT_NODE_A: begin
            slot_en = cfg.features[FE_NODE_A];
            slot_id = {cfg.drive_node_a, ESTOP_ID_LOW};
         end
         SLOT_NODE_B: begin
            slot_en = cfg.features[FE_NODE_B] && HAS_NODE_B;
            slot_id = {cfg.drive_node_b, ESTOP_ID_LOW};
         end
         SLOT_MOTOR_A_ON: begin
            slot_en    = cfg.features[FE_MOTOR_A];
            slot_id    = cfg.motor_id_a;
            slot_len   = FULL_LENGTH;
            slot_bytes = MOTOR_STOP;
         end
         SLOT_MOTOR_A_OFF: begin
            slot_en    = cfg.features[FE_MOTOR_A];
            slot_id    = cfg.motor_id_a;
            slot_len   = FULL_LENGTH;
            slot_bytes = MOTOR_OFF;
         end
         SLOT_MOTOR_B_ON: begin
            slot_en    = cfg.features[FE_MOTOR_B] && HAS_MOTOR_B;
            slot_id    = cfg.motor_id_b;
            slot_len   = FULL_LENGTH;
            slot_bytes = MOTOR_STOP;
         end
         SLOT_MOTOR_B_OFF: begin
            slot_en    = cfg.features[FE_MOTOR_B] && HAS_MOTOR_B;
            slot_id    = cfg.motor_id_b;
            slot_len   = FULL_LENGTH;
            slot_bytes = MOTOR_OFF;
         end
         default: slot_en = 1'b0;
      endcase
      // direct stop off empties every burst
      slot_en = slot_en && cfg.features[FE_DIRECT];
   end

   // walk one frame slot per step; after the bursts, send the status word and drop the job
   always_comb begin
      slot_in = slot_ff;
      pass_in = pass_ff;
      pop     = 1'b0;
      if (step) begin
         if (in_burst) begin
            if (slot_ff == SLOT_MOTOR_B_OFF) begin
               slot_in = SLOT_NODE_A;
               pass_in = pass_ff + 2'd1;
            end else begin
               slot_in = slot_type'(slot_ff + 3'd1);
            end
         end else begin
            pop     = 1'b1;
            slot_in = SLOT_NODE_A;
            pass_in = 2'd0;
         end
      end
   end

   assign load = step && (!in_burst || slot_en);

   always_comb begin
      valid_in   = load ? 1'b1 : (valid_ff && !out_ready);
      kind_in    = kind_ff;
      id_in      = id_ff;
      len_in     = len_ff;
      bytes_in   = bytes_ff;
      latched_in = latched_ff;
      active_in  = active_ff;
      cause_in   = cause_ff;
      clear_in   = clear_ff;
      last_in    = last_ff;
      if (load) begin
         kind_in    = in_burst;
         id_in      = in_burst ? slot_id : 11'd0;
         len_in     = in_burst ? slot_len : 4'd0;
         bytes_in   = in_burst ? slot_bytes : 64'd0;
         latched_in = job.latched;
         active_in  = job.active;
         cause_in   = job.cause;
         clear_in   = !in_burst && job.clear_done;
         last_in    = !in_burst;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      id_ff      <= id_in;
      len_ff     <= len_in;
      bytes_ff   <= bytes_in;
      latched_ff <= latched_in;
      active_ff  <= active_in;
      cause_ff   <= cause_in;
      clear_ff   <= clear_in;
      last_ff    <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= SLOT_NODE_A;
         pass_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         pass_ff  <= pass_in;
         valid_ff <= valid_in;
      end
   end

   assign out_valid      = valid_ff;
   assign out_kind       = kind_ff;
   assign out_tx_id      = id_ff;
   assign out_tx_length  = len_ff;
   assign out_tx_bytes   = bytes_ff;
   assign out_latched    = latched_ff;
   assign out_active     = active_ff;
   assign out_stop_cause = cause_ff;
   assign out_clear_done = clear_ff;
   assign out_last       = last_ff;

endmodule

/* rtl/safety_stop_latch_with_can_watchdog_unit.sv */
// The result word is registered; a disabled frame slot takes a step of its own without a word.
// Throughput: the front takes one item per cycle while its 4-entry job queue has room.
// The back sequencer walks one frame slot per step, 6 slots per burst, then sends the status word;
// an item carries up to two bursts, and the back sequencer waits while the result side stalls.
// Reset (synchronous, active high) restores register defaults and the latch state and
// empties the job queue and the output register.
module safety_stop_latch_with_can_watchdog_unit #(
   parameter int DRIVE_NODES = 2,
   parameter int MOTOR_IDS   = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // rx_id[10:0], rx_length[14:11], rx_bytes[78:15], flag[79]
   input  logic [2:0]  req_tuser,  // command[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,  // tx_id[10:0], tx_length[14:11], tx_bytes[78:15],
                                   // latched[79], active[80], stop_cause[83:81],
                                   // clear_done[84], zero[87:85]
   output logic        rsp_tuser,  // kind[0]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import sse_pkg::*;

   cfg_type     cfg;
   logic        queue_full;
   logic        push;
   job_type     push_job;
   logic        pop;
   logic        job_valid;
   job_type     job;
   logic        out_kind;
   logic [10:0] out_tx_id;
   logic [3:0]  out_tx_length;
   logic [63:0] out_tx_bytes;
   logic        out_latched;
   logic        out_active;
   logic [2:0]  out_stop_cause;
   logic        out_clear_done;

   sse_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   sse_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_command   (req_tuser),
      .in_rx_id     (req_tdata[10:0]),
      .in_rx_length (req_tdata[14:11]),
      .in_rx_bytes  (req_tdata[78:15]),
      .in_flag      (req_tdata[79]),
      .queue_full   (queue_full),
      .push         (push),
      .push_job     (push_job)
   );

   sse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .job_valid (job_valid),
      .job       (job)
   );

   sse_back #(
      .DRIVE_NODES (DRIVE_NODES),
      .MOTOR_IDS   (MOTOR_IDS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .job_valid      (job_valid),
      .job            (job),
      .pop            (pop),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_kind       (out_kind),
      .out_tx_id      (out_tx_id),
      .out_tx_length  (out_tx_length),
      .out_tx_bytes   (out_tx_bytes),
      .out_latched    (out_latched),
      .out_active     (out_active),
      .out_stop_cause (out_stop_cause),
      .out_clear_done (out_clear_done),
      .out_last       (rsp_tlast)
   );

   assign rsp_tuser = out_kind;
   assign rsp_tdata = {3'd0, out_clear_done, out_stop_cause, out_active, out_latched,
                       out_tx_bytes, out_tx_length, out_tx_id};

endmodule

/* tb/sv/stop_word_checker.sv */
module stop_word_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [79:0] req_tdata,  // rx_id[10:0], rx_length[14:11], rx_bytes[78:15], flag[79]
   input  logic [2:0]  req_tuser,  // command[2:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [87:0] rsp_tdata,  // tx_id[10:0], tx_length[14:11], tx_bytes[78:15],
                                   // latched[79], active[80], stop_cause[83:81],
                                   // clear_done[84], zero[87:85]
   input  logic        rsp_tuser,  // kind[0]
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          words_awaited
);
   timeunit 1ns;
   timeprecision 1ps;
   import sse_pkg::*;

   typedef struct packed {
      logic        kind;
      logic [10:0] tx_id;
      logic [3:0]  tx_length;
      logic [63:0] tx_bytes;
      logic        latched;
      logic        active;
      logic [2:0]  cause;
      logic        clear_done;
      logic        last;
   } stop_word_type;

   stop_word_type awaited_words[$];
   stop_word_type want;
   cfg_type       cfg;
   logic          latched_q;
   logic          enabled_q;
   cause_type     cause_q;
   logic          hb_seen_q;
   logic [15:0]   hb_value_q;
   logic [15:0]   ticks_q;
   logic [31:0]   reg_value;
   int            mismatches;

   function automatic void push_word(logic kind, logic [10:0] id, logic [3:0] len,
                                     logic [63:0] bytes, logic clear_done, logic last);
      stop_word_type w;
      w = '{kind, id, len, bytes, latched_q, enabled_q, cause_q, clear_done, last};
      awaited_words.insert(awaited_words.size(), w);
   endfunction

   function automatic void push_stop_burst();
      if (cfg.features[FE_DIRECT]) begin
         if (cfg.features[FE_NODE_A])
            push_word(1'b1, {cfg.drive_node_a, ESTOP_ID_LOW}, 4'd0, 64'd0, 1'b0, 1'b0);
         if (cfg.features[FE_NODE_B])
            push_word(1'b1, {cfg.drive_node_b, ESTOP_ID_LOW}, 4'd0, 64'd0, 1'b0, 1'b0);
         if (cfg.features[FE_MOTOR_A]) begin
            push_word(1'b1, cfg.motor_id_a, FULL_LENGTH, MOTOR_STOP, 1'b0, 1'b0);
            push_word(1'b1, cfg.motor_id_a, FULL_LENGTH, MOTOR_OFF, 1'b0, 1'b0);
         end
         if (cfg.features[FE_MOTOR_B]) begin
            push_word(1'b1, cfg.motor_id_b, FULL_LENGTH, MOTOR_STOP, 1'b0, 1'b0);
            push_word(1'b1, cfg.motor_id_b, FULL_LENGTH, MOTOR_OFF, 1'b0, 1'b0);
         end
      end
   endfunction

   function automatic void latch_stop(cause_type cause);
      latched_q = 1'b1;
      cause_q   = cause;
      push_stop_burst();
   endfunction

   function automatic void record_heartbeat(logic [15:0] hb);
      hb_value_q = hb;
      hb_seen_q  = 1'b1;
      ticks_q    = 16'd0;
   endfunction

   function automatic void predict_stop_words(logic [2:0] cmd, logic [10:0] id,
                                              logic [3:0] len, logic [63:0] bytes,
                                              logic flag);
      logic [10:0] status_id;
      logic [15:0] hb;
      logic [3:0]  eff_len;
      logic        monitoring;
      status_id  = cfg.button_base_id + 11'd1;
      // byte 6 is the high byte of the heartbeat counter
      hb         = {bytes[55:48], bytes[63:56]};
      eff_len    = (len > FULL_LENGTH) ? FULL_LENGTH : len;
      monitoring = enabled_q && cfg.features[FE_BUTTON];
      case (cmd)
         CMD_CAN_FRAME: begin
            if (monitoring) begin
               if (id == cfg.button_base_id && eff_len >= 4'd1 &&
                   bytes[7:0] == BTN_PRESSED) begin
                  latch_stop(CAUSE_BTN_EVENT);
                  push_word(1'b0, '0, '0, '0, 1'b0, 1'b1);
               end else if (id == status_id && eff_len >= 4'd2 &&
                            (bytes[15:8] & BTN_STAT_MASK) != 8'd0) begin
                  if (eff_len == FULL_LENGTH)
                     record_heartbeat(hb);
                  latch_stop(CAUSE_BTN_STAT);
                  push_word(1'b0, '0, '0, '0, 1'b0, 1'b1);
               end else if (id == status_id && eff_len == FULL_LENGTH &&
                            (!hb_seen_q || hb != hb_value_q)) begin
                  record_heartbeat(hb);
               end
            end
         end
         CMD_TICK: begin
            if (ticks_q != 16'hFFFF)
               ticks_q = ticks_q + 16'd1;
            if (monitoring && !latched_q && hb_seen_q && ticks_q > cfg.hb_timeout)
               latch_stop(CAUSE_HB_LOST);
            // a latched block repeats the burst on every tick
            if (enabled_q && latched_q)
               push_stop_burst();
            push_word(1'b0, '0, '0, '0, 1'b0, 1'b1);
         end
         CMD_EXT_STOP: begin
            if (enabled_q) begin
               latch_stop(CAUSE_EXTERNAL);
               push_word(1'b0, '0, '0, '0, 1'b0, 1'b1);
            end
         end
         CMD_CLEAR: begin
            if (flag) begin
               latched_q = 1'b0;
               cause_q   = CAUSE_NONE;
            end
            push_word(1'b0, '0, '0, '0, flag, 1'b1);
         end
         CMD_SET_ENABLE: begin
            enabled_q = flag;
            if (!flag) begin
               latched_q = 1'b0;
               cause_q   = CAUSE_NONE;
            end
            push_word(1'b0, '0, '0, '0, 1'b0, 1'b1);
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, logic [63:0] exp_val,
                                       logic [63:0] act_val);
      if (exp_val !== act_val) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg = '{button_base_id: 11'h200, hb_timeout: 16'd240, features: 6'h3F,
                 drive_node_a: 6'd0, drive_node_b: 6'd2,
                 motor_id_a: 11'd321, motor_id_b: 11'd322};
         latched_q  = 1'b0;
         enabled_q  = 1'b1;
         cause_q    = CAUSE_NONE;
         hb_seen_q  = 1'b0;
         hb_value_q = 16'd0;
         ticks_q    = 16'd0;
         awaited_words.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            case (csr_paddr[4:2])
               REG_BUTTON_BASE: reg_value = 32'(cfg.button_base_id);
               REG_HB_TIMEOUT:  reg_value = 32'(cfg.hb_timeout);
               REG_FEATURES:    reg_value = 32'(cfg.features);
               REG_DRIVE_A:     reg_value = 32'(cfg.drive_node_a);
               REG_DRIVE_B:     reg_value = 32'(cfg.drive_node_b);
               REG_MOTOR_A:     reg_value = 32'(cfg.motor_id_a);
               REG_MOTOR_B:     reg_value = 32'(cfg.motor_id_b);
               default:         reg_value = '0;
            endcase
            if (csr_pwrite) begin
               case (csr_paddr[4:2])
                  REG_BUTTON_BASE: cfg.button_base_id = csr_pwdata[10:0];
                  REG_HB_TIMEOUT:  cfg.hb_timeout     = csr_pwdata[15:0];
                  REG_FEATURES:    cfg.features       = csr_pwdata[5:0];
                  REG_DRIVE_A:     cfg.drive_node_a   = csr_pwdata[5:0];
                  REG_DRIVE_B:     cfg.drive_node_b   = csr_pwdata[5:0];
                  REG_MOTOR_A:     cfg.motor_id_a     = csr_pwdata[10:0];
                  REG_MOTOR_B:     cfg.motor_id_b     = csr_pwdata[10:0];
                  default: ;
               endcase
            end else begin
               check_field("register read", 64'(reg_value), 64'(csr_prdata));
            end
         end

         // retire the result word before predicting the item accepted at this edge
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_words.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result word, tdata %h kind %b last %b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = awaited_words.pop_front();
               check_field("kind", 64'(want.kind), 64'(rsp_tuser));
               check_field("tx_id", 64'(want.tx_id), 64'(rsp_tdata[10:0]));
               check_field("tx_length", 64'(want.tx_length), 64'(rsp_tdata[14:11]));
               check_field("tx_bytes", want.tx_bytes, rsp_tdata[78:15]);
               check_field("latched", 64'(want.latched), 64'(rsp_tdata[79]));
               check_field("active", 64'(want.active), 64'(rsp_tdata[80]));
               check_field("stop_cause", 64'(want.cause), 64'(rsp_tdata[83:81]));
               check_field("clear_done", 64'(want.clear_done), 64'(rsp_tdata[84]));
               check_field("pad", 64'd0, 64'(rsp_tdata[87:85]));
               check_field("last", 64'(want.last), 64'(rsp_tlast));
            end
         end

         if (req_tvalid && req_tready)
            predict_stop_words(req_tuser, req_tdata[10:0], req_tdata[14:11],
                               req_tdata[78:15], req_tdata[79]);
      end
      fail_count    <= mismatches;
      words_awaited <= awaited_words.size();
   end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sse_pkg::*;

   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 47;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata   = '0;  // rx_id[10:0], rx_length[14:11], rx_bytes[78:15], flag[79]
   logic [2:0]  req_tuser   = '0;  // command[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [87:0] rsp_tdata;         // tx_id[10:0], tx_length[14:11], tx_bytes[78:15],
                                   // latched[79], active[80], stop_cause[83:81],
                                   // clear_done[84], zero[87:85]
   logic        rsp_tuser;         // kind[0]
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [4:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          words_awaited;

   bit          no_idle        = 1'b0;
   bit          stall_receiver = 1'b0;
   logic [10:0] btn_base       = 11'h200;
   logic [15:0] last_hb        = '0;

   safety_stop_latch_with_can_watchdog_unit dut (.*);

   stop_word_checker checker_i (.*);

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #15ms;
      $display("safety_stop_latch_with_can_watchdog_unit verification failed");
      $finish;
   end

   // result side: random stalls per word, one long hold-off on request
   initial begin
      int stall;
      wait (!reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 18);
         if (stall_receiver) begin
            stall          = LONG_HOLD;
            stall_receiver = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_item(input logic [2:0] cmd, input logic [10:0] id,
                            input logic [3:0] len, input logic [63:0] bytes,
                            input logic flag);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {flag, bytes, len, id};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic access_reg(input logic wr, input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [10:0] base, input logic [15:0] timeout,
                               input logic [5:0] feat, input logic [5:0] node_a,
                               input logic [5:0] node_b, input logic [10:0] motor_a,
                               input logic [10:0] motor_b);
      logic [31:0] vals [7];
      vals = '{32'(base), 32'(timeout), 32'(feat), 32'(node_a), 32'(node_b),
               32'(motor_a), 32'(motor_b)};
      for (int i = REG_BUTTON_BASE; i <= REG_MOTOR_B; i++)
         access_reg(1'b1, 3'(i), vals[i]);
      for (int i = REG_BUTTON_BASE; i <= REG_MOTOR_B; i++)
         access_reg(1'b0, 3'(i), '0);
      btn_base = base;
   endtask

   // hold the input low until every awaited word is back, then let the block go quiet
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (words_awaited != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_random_item();
      logic [2:0]  cmd;
      logic [10:0] id;
      logic [3:0]  len;
      logic [63:0] bytes;
      logic        flag;
      int          pick;
      pick  = $urandom_range(0, 99);
      id    = 11'($urandom_range(0, 2047));
      len   = 4'($urandom_range(0, 15));
      bytes = {$urandom, $urandom};
      flag  = 1'($urandom_range(0, 1));
      if (pick < 32) begin
         cmd = CMD_TICK;
      end else if (pick < 62) begin
         cmd = CMD_CAN_FRAME;
         case ($urandom_range(0, 3))
            0: begin
               id = btn_base;
               if ($urandom_range(0, 1) != 0)
                  bytes[7:0] = BTN_PRESSED;
            end
            1, 2: begin
               id = btn_base + 11'd1;
               if ($urandom_range(0, 3) != 0)
                  len = FULL_LENGTH;
               if ($urandom_range(0, 2) != 0)
                  bytes[15:8] = bytes[15:8] & ~BTN_STAT_MASK;
               // repeat the previous counter now and then so the watchdog can expire
               if ($urandom_range(0, 1) != 0)
                  bytes[63:48] = last_hb;
               last_hb = bytes[63:48];
            end
            default: ;
         endcase
      end else if (pick < 72) begin
         cmd = CMD_EXT_STOP;
      end else if (pick < 87) begin
         cmd = CMD_CLEAR;
      end else if (pick < 97) begin
         cmd  = CMD_SET_ENABLE;
         flag = ($urandom_range(0, 3) != 0);
      end else begin
         cmd = CMD_SET_ENABLE + 3'($urandom_range(1, 3));
      end
      send_item(cmd, id, len, bytes, flag);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults: button id 0x200, status id 0x201, all features on
      send_item(CMD_TICK, '0, '0, '0, 1'b0);
      send_item(CMD_CAN_FRAME, 11'h201, 4'd8, 64'h1234_0000_0000_0000, 1'b0);
      send_item(CMD_CAN_FRAME, 11'h200, 4'd1, 64'h01, 1'b0);
      send_item(CMD_TICK, '0, '0, '0, 1'b0);
      send_item(CMD_CLEAR, '0, '0, '0, 1'b0);
      send_item(CMD_CLEAR, '0, '0, '0, 1'b1);
      send_item(CMD_CAN_FRAME, 11'h201, 4'd2, 64'h1000, 1'b0);
      send_item(CMD_CLEAR, '0, '0, '0, 1'b1);
      // over-long frame is taken as eight bytes
      send_item(CMD_CAN_FRAME, 11'h201, 4'd15, 64'hFFFF_FFFF_FFFF_01FF, 1'b1);
      send_item(CMD_CLEAR, '0, '0, '0, 1'b1);
      send_item(CMD_CAN_FRAME, 11'h200, 4'd0, 64'h01, 1'b0);
      send_item(CMD_EXT_STOP, '0, '0, '0, 1'b0);
      send_item(CMD_SET_ENABLE, '0, '0, '0, 1'b0);
      send_item(CMD_EXT_STOP, '0, '0, '0, 1'b0);
      send_item(CMD_CAN_FRAME, 11'h200, 4'd8, 64'h01, 1'b0);
      send_item(CMD_TICK, '0, '0, '0, 1'b0);
      send_item(CMD_CLEAR, '0, '0, '0, 1'b1);
      send_item(CMD_SET_ENABLE, '0, '0, '0, 1'b1);
      for (int c = CMD_SET_ENABLE + 1; c < 8; c++)
         send_item(3'(c), 11'h200, 4'd8, 64'h01, 1'b1);
      send_item(CMD_CAN_FRAME, '1, '1, '1, 1'b1);
      send_item(CMD_CAN_FRAME, '0, '0, '0, 1'b0);
      drain_results();

      // status id wraps to zero; zero timeout trips on the first quiet tick
      program_regs('1, '0, '1, '1, '1, '1, '0);
      send_item(CMD_CAN_FRAME, 11'h000, 4'd8, 64'hCDAB_0000_0000_0000, 1'b0);
      send_item(CMD_TICK, '0, '0, '0, 1'b0);
      send_item(CMD_TICK, '0, '0, '0, 1'b0);
      send_item(CMD_CLEAR, '0, '0, '0, 1'b1);
      drain_results();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: program_regs('0, '0, '0, '0, '0, '0, '0);
            1: program_regs('1, '1, '1, '1, '1, '1, '1);
            default:
               program_regs(11'($urandom_range(0, 2047)), 16'($urandom_range(0, 24)),
                            6'($urandom_range(0, 63)) | (($urandom_range(0, 2) != 0) ?
                                                         6'h21 : 6'h00),
                            6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                            11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
         endcase
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 13 == 0)
               no_idle = (p == 2 && k == 13) || ($urandom_range(0, 2) == 0);
            // keep offering words back to back while the result side holds off
            if (p == 2 && k == 13)
               stall_receiver = 1'b1;
            if (p == 3 && k == 26)
               drain_results();
            send_random_item();
         end
         drain_results();
      end

      if (fail_count == 0 && words_awaited == 0)
         $display("safety_stop_latch_with_can_watchdog_unit verification clean");
      else
         $display("safety_stop_latch_with_can_watchdog_unit verification failed");
      $finish;
   end

endmodule
